>>> hdl/smbr_pkg.sv
// ----------------------------------------------------------------------------
// smbr_pkg
// Shared types and constants for the bounded SplitMix64 generator.
// ----------------------------------------------------------------------------
package smbr_pkg;

  localparam logic [63:0] GoldenInc = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixMulA   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB   = 64'h94D049BB133111EB;

  localparam logic [1:0] KindBounded = 2'd0;
  localparam logic [1:0] KindBytes   = 2'd1;
  localparam logic [1:0] KindDouble  = 2'd2;
  localparam logic [1:0] KindNone    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] range_n;
    logic [3:0]  byte_count;
  } req_t;

  typedef struct packed {
    logic [63:0] value;
  } rsp_t;

endpackage

>>> hdl/smbr_if.sv
// ----------------------------------------------------------------------------
// smbr_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface smbr_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/splitmix64_bounded_rng.sv
// ----------------------------------------------------------------------------
// splitmix64_bounded_rng
// SplitMix64 generator giving bounded integers, masked bytes or unit doubles.
// ----------------------------------------------------------------------------
// Requests arrive on req (kind, range_n, byte_count); one result per request
// leaves on rsp. seed_we_i/seed_i reload the state with the seed
// zero-extended; write only while idle.
// One 64x16 multiplier is shared: each 64-bit mix multiply and the 32x32
// bound multiply are summed from 16-bit slices of their operand. A draw
// is add, mul A, mul B; for bounded requests rejection adds a draw per
// retry, and computing the threshold runs a restoring divider. Double
// requests add a 1-bit-a-cycle normalising shift. Trivial requests skip
// the draw and go straight to StOut with a zero result.
// The block takes one request at a time; req.ready is low meanwhile and
// while a result waits in the output register, so the next request is
// taken only after the result leaves. A stalled receiver holds the result
// stable. Reset loads state 1 and seed 1, no clearing pass.
// ----------------------------------------------------------------------------
module splitmix64_bounded_rng (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seed_we_i,
  input  logic [31:0] seed_i,
  smbr_if.sink        req,
  smbr_if.source      rsp
);

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StAdd   = 10'b0000000010,
    StMulA  = 10'b0000000100,
    StMulB  = 10'b0000001000,
    StFin   = 10'b0000010000,
    StBnd   = 10'b0000100000,
    StDiv   = 10'b0001000000,
    StChk   = 10'b0010000000,
    StNorm  = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e      state_q, state_d;
  logic [63:0] rng_q;
  smbr_pkg::req_t req_q;
  logic [63:0] acc_q, z_q;
  logic [1:0]  part_q;
  logic [31:0] lim_q, rem_q;
  logic [5:0]  cnt_q;
  logic        lim_ok_q;
  logic [63:0] val_q;
  logic        vld_q;

  // shared multiplier: z_q times one 16-bit slice of the operand
  logic [63:0] mop;
  logic [15:0] slice;
  logic [79:0] pp;
  always_comb begin
    unique case (state_q)
      StMulA:  mop = smbr_pkg::MixMulA;
      StMulB:  mop = smbr_pkg::MixMulB;
      default: mop = {32'd0, req_q.range_n};
    endcase
    slice = mop[16*part_q +: 16];
    pp    = z_q * slice;
  end

  logic [63:0] shifted;
  assign shifted = pp[63:0] << (16 * part_q);

  logic [3:0] bc_sat;
  assign bc_sat = (req_q.byte_count > 4'd8) ? 4'd8 : req_q.byte_count;

  logic [63:0] mix;
  assign mix = z_q ^ (z_q >> 31);

  logic [32:0] rem_try;
  assign rem_try = {rem_q, lim_q[31]} - {1'b0, req_q.range_n};

  logic trivial;
  always_comb begin
    unique case (req.data.kind)
      smbr_pkg::KindBounded: trivial = req.data.range_n <= 32'd1;
      smbr_pkg::KindBytes:   trivial = req.data.byte_count == 4'd0;
      smbr_pkg::KindDouble:  trivial = 1'b0;
      default:               trivial = 1'b1;
    endcase
  end

  assign req.ready = (state_q == StIdle) && !vld_q;
  assign rsp.valid = vld_q;
  assign rsp.data.value = val_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (req.valid && req.ready) state_d = trivial ? StOut : StAdd;
      StAdd:   state_d = StMulA;
      StMulA:  if (part_q == 2'd3) state_d = StMulB;
      StMulB:  if (part_q == 2'd3) state_d = StFin;
      StFin:   begin
        unique case (req_q.kind)
          smbr_pkg::KindBounded: state_d = StBnd;
          smbr_pkg::KindDouble:  state_d = StNorm;
          default:               state_d = StOut;
        endcase
      end
      StBnd:   if (part_q == 2'd1) state_d = StChk;
      StDiv:   if (cnt_q == 6'd31) state_d = StChk;
      StChk:   begin
        if (acc_q[31:0] >= req_q.range_n) state_d = StOut;
        else if (!lim_ok_q) state_d = StDiv;
        else if (acc_q[31:0] < lim_q) state_d = StAdd;
        else state_d = StOut;
      end
      StNorm:  if (z_q == 64'd0 || z_q[52]) state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rng_q    <= 64'd1;
      vld_q    <= 1'b0;
      part_q   <= 2'd0;
      cnt_q    <= 6'd0;
      lim_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rsp.valid && rsp.ready) vld_q <= 1'b0;
      if (seed_we_i) rng_q <= {32'd0, seed_i};
      unique case (state_q)
        StIdle: begin
          if (req.valid && req.ready) begin
            req_q    <= req.data;
            lim_ok_q <= 1'b0;
            val_q    <= 64'd0;
          end
        end
        StAdd: begin
          rng_q  <= rng_q + smbr_pkg::GoldenInc;
          z_q    <= (rng_q + smbr_pkg::GoldenInc) ^
                    ((rng_q + smbr_pkg::GoldenInc) >> 30);
          acc_q  <= 64'd0;
          part_q <= 2'd0;
        end
        StMulA, StMulB: begin
          part_q <= part_q + 2'd1;
          if (part_q == 2'd3) begin
            if (state_q == StMulA) begin
              z_q <= (acc_q + shifted) ^ ((acc_q + shifted) >> 27);
            end else begin
              z_q <= acc_q + shifted;
            end
            acc_q <= 64'd0;
          end else begin
            acc_q <= acc_q + shifted;
          end
        end
        StFin: begin
          part_q <= 2'd0;
          acc_q  <= 64'd0;
          unique case (req_q.kind)
            smbr_pkg::KindBounded: z_q <= {32'd0, mix[31:0]};
            smbr_pkg::KindDouble:  z_q <= mix >> 11;
            default: begin
              if (bc_sat == 4'd8) val_q <= mix;
              else val_q <= mix & ((64'd1 << {bc_sat, 3'd0}) - 64'd1);
            end
          endcase
          cnt_q <= 6'd52;
        end
        StBnd: begin
          part_q <= part_q + 2'd1;
          acc_q  <= acc_q + shifted;
        end
        StChk: begin
          val_q <= {32'd0, acc_q[63:32]};
          if (acc_q[31:0] < req_q.range_n && !lim_ok_q) begin
            // threshold = (2^32 - n) mod n, restoring divide
            lim_q <= 32'd0 - req_q.range_n;
            rem_q <= 32'd0;
            cnt_q <= 6'd0;
          end
        end
        StDiv: begin
          cnt_q <= cnt_q + 6'd1;
          if (!rem_try[32]) rem_q <= rem_try[31:0];
          else rem_q <= {rem_q[30:0], lim_q[31]};
          if (cnt_q == 6'd31) begin
            lim_q    <= !rem_try[32] ? rem_try[31:0] : {rem_q[30:0], lim_q[31]};
            lim_ok_q <= 1'b1;
          end else begin
            lim_q <= {lim_q[30:0], 1'b0};
          end
        end
        StNorm: begin
          if (z_q == 64'd0) begin
            val_q <= 64'd0;
          end else if (z_q[52]) begin
            val_q <= {1'b0, 11'd970 + {5'd0, cnt_q}, z_q[51:0]};
          end else begin
            z_q   <= z_q << 1;
            cnt_q <= cnt_q - 6'd1;
          end
        end
        StOut: vld_q <= 1'b1;
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> state_q == StIdle)
    else $error("ready outside idle");
  a_one_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut |=> rsp.valid)
    else $error("result not raised");
  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready)
    else $error("request taken while result pending");

endmodule
